[hdl/tlbpt_pkg.sv]
package tlbpt_pkg;

    // Fixed field widths of the stream ports
    localparam int VA_W    = 16;
    localparam int PA_W    = 15;
    localparam int TOTAL_W = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TOUCH,
        ST_DONE
    } state_t;

    // Which pair of memories the sequencer is working on
    typedef enum logic {
        TBL_TLB,
        TBL_FRM
    } tbl_t;

    // Status from the shared compare unit
    typedef struct packed {
        logic tag_eq;   // stored tag equals the current page
        logic below;    // rank is more recent than the reference rank
        logic target;   // this entry becomes most recently used
    } cmp_t;

endpackage

[hdl/tlbpt_ram.sv]
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tlbpt_rank_unit.sv]
module tlbpt_rank_unit #(
    parameter int RANK_W = 7,
    parameter int TAG_W  = 8
) (
    input  logic [TAG_W-1:0]  tag,
    input  logic [TAG_W-1:0]  page,
    input  logic [RANK_W-1:0] rank,
    input  logic [RANK_W-1:0] ref_rank,
    input  logic [RANK_W-1:0] index,
    input  logic              fill,
    output logic [RANK_W-1:0] new_rank,
    output tlbpt_pkg::cmp_t   cmp
);

    // Tag match and LRU rank compares, shared by both tables
    always_comb
    begin
        cmp.tag_eq = (tag == page);
        cmp.below  = (rank < ref_rank);
        // fill: the new slot sits at index ref_rank; otherwise the entry holding ref_rank
        cmp.target = fill ? (index == ref_rank) : (rank == ref_rank);
    end

    // Touched entry goes to rank zero, more recent ones age by one
    always_comb
    begin
        if (cmp.target)
        begin
            new_rank = '0;
        end
        else if (cmp.below)
        begin
            new_rank = rank + RANK_W'(1);
        end
        else
        begin
            new_rank = rank;
        end
    end

endmodule

[hdl/tlb_lru_page_translate.sv]
// Channel   Dir  Payload (low bit first)                                  Handshake
// s_axis    in   tdata: virtual_address[15:0]                             tvalid/tready
// m_axis    out  tdata: physical_address[14:0], tlb_hit_total[46:15],     tvalid/tready
//                       fault_total[78:47], zero pad [79]
//                tuser: tlb_hit[0], page_fault[1]
//
// One request at a time. TLB hit: a TLB scan up to the matching entry, then a TLB
// rank update. Miss: TLB scan, frame tag scan, frame rank update, TLB rank update.
// Each pass is paced by the single read port of each table memory, walked one entry
// per cycle through the shared unit.
// Reset clears fill counts, totals and control; memories need no clearing.
// A finished result waits in the output register; the next request is taken meanwhile.
module tlb_lru_page_translate #(
    parameter int TLB_ENTRIES = 16,
    parameter int NUM_FRAMES  = 128,
    parameter int OFFSET_BITS = 8,
    parameter int PAGE_BITS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // virtual_address[15:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // physical_address, tlb_hit_total, fault_total, pad
    output logic [1:0]  m_axis_tuser    // tlb_hit, page_fault
);

    localparam int TIDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int TCNT_W = $clog2(TLB_ENTRIES + 1);
    localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FCNT_W = $clog2(NUM_FRAMES + 1);
    localparam int RANK_W = (TIDX_W > FIDX_W) ? TIDX_W : FIDX_W;
    localparam int CNT_W  = (TCNT_W > FCNT_W) ? TCNT_W : FCNT_W;
    localparam int ENT_W  = FIDX_W + PAGE_BITS;

    localparam int PA_W    = tlbpt_pkg::PA_W;
    localparam int TOTAL_W = tlbpt_pkg::TOTAL_W;

    // Control state
    tlbpt_pkg::state_t state_reg, state_next;
    tlbpt_pkg::tbl_t   tbl_reg, tbl_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [RANK_W-1:0] ref_reg, ref_next;
    logic              fill_reg, fill_next;
    logic              hit_reg, hit_next;
    logic              fault_reg, fault_next;
    logic [FIDX_W-1:0] frame_reg, frame_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [TOTAL_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [TOTAL_W-1:0] flt_cnt_reg, flt_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Request payload
    logic [PAGE_BITS-1:0]   page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [31:0]            va_wide;

    // Result payload
    logic [PA_W-1:0]    pa_out_reg;
    logic               hit_out_reg;
    logic               fault_out_reg;
    logic [TOTAL_W-1:0] hit_tot_out_reg;
    logic [TOTAL_W-1:0] flt_tot_out_reg;
    logic [31:0]        pa_wide;

    // Memory ports
    logic                 tlb_re, frm_re;
    logic                 tlb_ent_we, tlb_rank_we, frm_tag_we, frm_rank_we;
    logic [ENT_W-1:0]     tlb_ent_rdata;
    logic [TIDX_W-1:0]    tlb_rank_rdata;
    logic [PAGE_BITS-1:0] frm_tag_rdata;
    logic [FIDX_W-1:0]    frm_rank_rdata;

    // Shared unit
    logic [RANK_W-1:0]    rank_rd;
    logic [PAGE_BITS-1:0] tag_rd;
    logic [RANK_W-1:0]    new_rank;
    tlbpt_pkg::cmp_t      cmp;

    // Sequencer helpers
    logic              accept_in;
    logic              issue;
    logic              last;
    logic              done_load;
    logic              f_full, t_full;
    logic [RANK_W-1:0] pt_ref, ti_ref;
    logic [CNT_W-1:0]  pt_len, ti_len;

    assign va_wide   = 32'(s_axis_tdata);
    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == tlbpt_pkg::ST_IDLE);

    // Table memories
    tlbpt_ram #(.WIDTH(ENT_W), .DEPTH(TLB_ENTRIES)) u_tlb_ent_ram (
        .clk   (clk),
        .we    (tlb_ent_we),
        .waddr (rd_idx_reg[TIDX_W-1:0]),
        .wdata ({frame_reg, page_reg}),
        .re    (tlb_re),
        .raddr (idx_reg[TIDX_W-1:0]),
        .rdata (tlb_ent_rdata)
    );

    tlbpt_ram #(.WIDTH(TIDX_W), .DEPTH(TLB_ENTRIES)) u_tlb_rank_ram (
        .clk   (clk),
        .we    (tlb_rank_we),
        .waddr (rd_idx_reg[TIDX_W-1:0]),
        .wdata (new_rank[TIDX_W-1:0]),
        .re    (tlb_re),
        .raddr (idx_reg[TIDX_W-1:0]),
        .rdata (tlb_rank_rdata)
    );

    tlbpt_ram #(.WIDTH(PAGE_BITS), .DEPTH(NUM_FRAMES)) u_frm_tag_ram (
        .clk   (clk),
        .we    (frm_tag_we),
        .waddr (rd_idx_reg[FIDX_W-1:0]),
        .wdata (page_reg),
        .re    (frm_re),
        .raddr (idx_reg[FIDX_W-1:0]),
        .rdata (frm_tag_rdata)
    );

    tlbpt_ram #(.WIDTH(FIDX_W), .DEPTH(NUM_FRAMES)) u_frm_rank_ram (
        .clk   (clk),
        .we    (frm_rank_we),
        .waddr (rd_idx_reg[FIDX_W-1:0]),
        .wdata (new_rank[FIDX_W-1:0]),
        .re    (frm_re),
        .raddr (idx_reg[FIDX_W-1:0]),
        .rdata (frm_rank_rdata)
    );

    // Read data of the table in use feeds the shared unit
    assign rank_rd = (tbl_reg == tlbpt_pkg::TBL_FRM) ? RANK_W'(frm_rank_rdata)
                                                     : RANK_W'(tlb_rank_rdata);
    assign tag_rd  = (tbl_reg == tlbpt_pkg::TBL_FRM) ? frm_tag_rdata
                                                     : tlb_ent_rdata[PAGE_BITS-1:0];

    tlbpt_rank_unit #(.RANK_W(RANK_W), .TAG_W(PAGE_BITS)) u_rank_unit (
        .tag      (tag_rd),
        .page     (page_reg),
        .rank     (rank_rd),
        .ref_rank (ref_reg),
        .index    (rd_idx_reg[RANK_W-1:0]),
        .fill     (fill_reg),
        .new_rank (new_rank),
        .cmp      (cmp)
    );

    // Pass bookkeeping
    assign issue = ((state_reg == tlbpt_pkg::ST_SCAN) || (state_reg == tlbpt_pkg::ST_TOUCH))
                   && (idx_reg < len_reg);
    assign last  = rd_vld_reg && (rd_idx_reg == (len_reg - CNT_W'(1)));
    assign tlb_re = issue && (tbl_reg == tlbpt_pkg::TBL_TLB);
    assign frm_re = issue && (tbl_reg == tlbpt_pkg::TBL_FRM);
    assign done_load = (state_reg == tlbpt_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    // Setup for a page fault: next free frame, or reclaim the oldest
    assign f_full = (fcnt_reg == FCNT_W'(NUM_FRAMES));
    assign pt_ref = f_full ? RANK_W'(NUM_FRAMES - 1) : RANK_W'(fcnt_reg);
    assign pt_len = f_full ? CNT_W'(NUM_FRAMES) : (CNT_W'(fcnt_reg) + CNT_W'(1));

    // Setup for a TLB insert: next free entry, or evict the oldest
    assign t_full = (tcnt_reg == TCNT_W'(TLB_ENTRIES));
    assign ti_ref = t_full ? RANK_W'(TLB_ENTRIES - 1) : RANK_W'(tcnt_reg);
    assign ti_len = t_full ? CNT_W'(TLB_ENTRIES) : (CNT_W'(tcnt_reg) + CNT_W'(1));

    // Sequencer: next state and memory writes
    always_comb
    begin
        state_next     = state_reg;
        tbl_next       = tbl_reg;
        idx_next       = issue ? (idx_reg + CNT_W'(1)) : idx_reg;
        rd_vld_next    = issue;
        rd_idx_next    = idx_reg;
        len_next       = len_reg;
        ref_next       = ref_reg;
        fill_next      = fill_reg;
        hit_next       = hit_reg;
        fault_next     = fault_reg;
        frame_next     = frame_reg;
        tcnt_next      = tcnt_reg;
        fcnt_next      = fcnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        flt_cnt_next   = flt_cnt_reg;
        out_valid_next = out_valid_reg;
        tlb_ent_we     = 1'b0;
        tlb_rank_we    = 1'b0;
        frm_tag_we     = 1'b0;
        frm_rank_we    = 1'b0;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tlbpt_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    hit_next    = 1'b0;
                    fault_next  = 1'b0;
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    if (tcnt_reg != '0)
                    begin
                        state_next = tlbpt_pkg::ST_SCAN;
                        tbl_next   = tlbpt_pkg::TBL_TLB;
                        len_next   = CNT_W'(tcnt_reg);
                    end
                    else if (fcnt_reg != '0)
                    begin
                        state_next = tlbpt_pkg::ST_SCAN;
                        tbl_next   = tlbpt_pkg::TBL_FRM;
                        len_next   = CNT_W'(fcnt_reg);
                    end
                    else
                    begin
                        state_next = tlbpt_pkg::ST_TOUCH;
                        tbl_next   = tlbpt_pkg::TBL_FRM;
                        fault_next = 1'b1;
                        ref_next   = pt_ref;
                        len_next   = pt_len;
                        fill_next  = !f_full;
                    end
                end
            end

            tlbpt_pkg::ST_SCAN:
            begin
                if (rd_vld_reg && cmp.tag_eq)
                begin
                    // hit: touch the matching entry with its own rank
                    state_next  = tlbpt_pkg::ST_TOUCH;
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    ref_next    = rank_rd;
                    fill_next   = 1'b0;
                    if (tbl_reg == tlbpt_pkg::TBL_TLB)
                    begin
                        hit_next   = 1'b1;
                        frame_next = tlb_ent_rdata[PAGE_BITS +: FIDX_W];
                        len_next   = CNT_W'(tcnt_reg);
                    end
                    else
                    begin
                        frame_next = rd_idx_reg[FIDX_W-1:0];
                        len_next   = CNT_W'(fcnt_reg);
                    end
                end
                else if (last)
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    tbl_next    = tlbpt_pkg::TBL_FRM;
                    if ((tbl_reg == tlbpt_pkg::TBL_TLB) && (fcnt_reg != '0))
                    begin
                        len_next = CNT_W'(fcnt_reg);
                    end
                    else
                    begin
                        state_next = tlbpt_pkg::ST_TOUCH;
                        fault_next = 1'b1;
                        ref_next   = pt_ref;
                        len_next   = pt_len;
                        fill_next  = !f_full;
                    end
                end
            end

            tlbpt_pkg::ST_TOUCH:
            begin
                if (rd_vld_reg)
                begin
                    if (tbl_reg == tlbpt_pkg::TBL_FRM)
                    begin
                        frm_rank_we = 1'b1;
                        if (cmp.target && fault_reg)
                        begin
                            frm_tag_we = 1'b1;
                            frame_next = rd_idx_reg[FIDX_W-1:0];
                        end
                    end
                    else
                    begin
                        tlb_rank_we = 1'b1;
                        if (cmp.target && !hit_reg)
                        begin
                            tlb_ent_we = 1'b1;
                        end
                    end
                end
                if (last)
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    if (tbl_reg == tlbpt_pkg::TBL_FRM)
                    begin
                        fcnt_next = fcnt_reg + FCNT_W'(fill_reg);
                        tbl_next  = tlbpt_pkg::TBL_TLB;
                        ref_next  = ti_ref;
                        len_next  = ti_len;
                        fill_next = !t_full;
                    end
                    else
                    begin
                        tcnt_next  = tcnt_reg + TCNT_W'(fill_reg);
                        state_next = tlbpt_pkg::ST_DONE;
                    end
                end
            end

            tlbpt_pkg::ST_DONE:
            begin
                if (done_load)
                begin
                    state_next     = tlbpt_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    if (hit_reg && (hit_cnt_reg != '1))
                    begin
                        hit_cnt_next = hit_cnt_reg + TOTAL_W'(1);
                    end
                    if (fault_reg && (flt_cnt_reg != '1))
                    begin
                        flt_cnt_next = flt_cnt_reg + TOTAL_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = tlbpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlbpt_pkg::ST_IDLE;
            tbl_reg       <= tlbpt_pkg::TBL_TLB;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            len_reg       <= '0;
            ref_reg       <= '0;
            fill_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            fault_reg     <= 1'b0;
            frame_reg     <= '0;
            tcnt_reg      <= '0;
            fcnt_reg      <= '0;
            hit_cnt_reg   <= '0;
            flt_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tbl_reg       <= tbl_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            len_reg       <= len_next;
            ref_reg       <= ref_next;
            fill_reg      <= fill_next;
            hit_reg       <= hit_next;
            fault_reg     <= fault_next;
            frame_reg     <= frame_next;
            tcnt_reg      <= tcnt_next;
            fcnt_reg      <= fcnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            flt_cnt_reg   <= flt_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Physical address from frame and offset, upper bits dropped
    assign pa_wide = (32'(frame_reg) << OFFSET_BITS) | 32'(offset_reg);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            page_reg   <= va_wide[OFFSET_BITS +: PAGE_BITS];
            offset_reg <= va_wide[OFFSET_BITS-1:0];
        end
        if (done_load)
        begin
            pa_out_reg      <= pa_wide[PA_W-1:0];
            hit_out_reg     <= hit_reg;
            fault_out_reg   <= fault_reg;
            hit_tot_out_reg <= hit_cnt_next;
            flt_tot_out_reg <= flt_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, flt_tot_out_reg, hit_tot_out_reg, pa_out_reg};
    assign m_axis_tuser  = {fault_out_reg, hit_out_reg};

`ifndef SYNTHESIS
    // A request is never both a TLB hit and a page fault
    a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlbpt_pkg::ST_DONE) |-> !(hit_reg && fault_reg))
        else $error("hit and fault both set");

    // Rank memories are written only from valid read data during an update pass
    a_rank_write: assert property (@(posedge clk) disable iff (!rst_n)
        (tlb_rank_we || frm_rank_we) |-> ((state_reg == tlbpt_pkg::ST_TOUCH) && rd_vld_reg))
        else $error("rank write outside update pass");

    // Frame fill count grows by at most one per cycle and never passes the table size
    a_fcnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((fcnt_reg == $past(fcnt_reg)) || (fcnt_reg == ($past(fcnt_reg) + 1'b1)))
                 && (fcnt_reg <= FCNT_W'(NUM_FRAMES)))
        else $error("frame fill count out of step");

    // Tag writes happen only on a miss path
    a_tag_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!frm_tag_we || fault_reg) && (!tlb_ent_we || !hit_reg))
        else $error("tag write on hit path");

    // Hit total never goes down
    a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hit_cnt_reg >= $past(hit_cnt_reg)))
        else $error("hit total decreased");
`endif

endmodule

[tb/sv/tlb_lru_page_translate_tb.sv]
`timescale 1ns / 100ps

module tlb_lru_page_translate_tb;

    localparam int PA_W         = tlbpt_pkg::PA_W;
    localparam int TOTAL_W      = tlbpt_pkg::TOTAL_W;
    localparam int TLB_N        = 16;
    localparam int FRM_N        = 128;
    localparam int OFS_W        = 8;
    localparam int RAND_ITEMS   = 1150;
    localparam int MAX_WAIT     = 16;
    localparam int DRAIN_CYCLES = 320;
    localparam int MAX_PRINTS   = 100;
    localparam int HOT_N        = 6;
    localparam int WARM_N       = 40;

    // Directed requests: address extremes, repeat hits, TLB overflow, re-walk of an evicted page
    localparam logic [15:0] CORNER_VA [22] = '{
        16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA,
        16'h1010, 16'h1111, 16'h1212, 16'h1313, 16'h1414, 16'h1515, 16'h1616, 16'h1717,
        16'h1818, 16'h1919, 16'h1A1A, 16'h1B1B, 16'h0042, 16'hFFFF
    };

    // Expected translation for one request
    typedef struct packed {
        logic [PA_W-1:0]    pa;
        logic               hit;
        logic               fault;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] fault_total;
    } xlat_t;

    // Scoreboard: shadow TLB and page table, queue of pending translations
    class xlat_tracker;
        logic [7:0]   tlb_tag  [TLB_N];
        logic [6:0]   tlb_frm  [TLB_N];
        bit           tlb_vld  [TLB_N];
        int           tlb_rank [TLB_N];
        logic [7:0]   frm_tag  [FRM_N];
        int           frm_rank [FRM_N];
        int           tlb_used;
        int           frm_used;
        logic [31:0]  hits;
        logic [31:0]  faults;
        int           errors;
        xlat_t        pending_xlat[$];

        function new();
            foreach (tlb_vld[i])
            begin
                tlb_vld[i]  = 1'b0;
                tlb_rank[i] = 0;
            end
            foreach (frm_rank[i])
                frm_rank[i] = 0;
            tlb_used = 0;
            frm_used = 0;
            hits     = '0;
            faults   = '0;
            errors   = 0;
        endfunction

        // Move TLB entry e to most recently used among the first n
        function void touch_tlb(int e, int n);
            int r;
            r = tlb_rank[e];
            for (int i = 0; i < n; i++)
                if (tlb_rank[i] < r)
                    tlb_rank[i]++;
            tlb_rank[e] = 0;
        endfunction

        function void touch_frame(int e, int n);
            int r;
            r = frm_rank[e];
            for (int i = 0; i < n; i++)
                if (frm_rank[i] < r)
                    frm_rank[i]++;
            frm_rank[e] = 0;
        endfunction

        // Translate one virtual address and advance the shadow state
        function xlat_t translate(logic [15:0] va);
            logic [7:0] page;
            int         frame;
            int         e;
            int         i;
            bit         hit;
            bit         found;
            xlat_t      res;
            page  = va[15:8];
            frame = 0;
            e     = 0;
            hit   = 1'b0;
            found = 1'b0;

            // TLB lookup
            for (i = 0; i < tlb_used && !hit; i++)
                if (tlb_vld[i] && tlb_tag[i] == page)
                begin
                    hit   = 1'b1;
                    e     = i;
                    frame = tlb_frm[i];
                end
            if (hit)
                touch_tlb(e, tlb_used);

            if (!hit)
            begin
                // Page table walk
                for (i = 0; i < frm_used && !found; i++)
                    if (frm_tag[i] == page)
                    begin
                        found = 1'b1;
                        frame = i;
                    end
                if (found)
                    touch_frame(frame, frm_used);
                else if (frm_used < FRM_N)
                begin
                    // fresh frame in allocation order
                    frame = frm_used;
                    for (i = 0; i < frame; i++)
                        frm_rank[i]++;
                    frm_rank[frame] = 0;
                    frm_used++;
                end
                else
                begin
                    // reclaim the LRU frame; stale TLB entries are left alone
                    frame = 0;
                    for (i = 0; i < FRM_N; i++)
                        if (frm_rank[i] == FRM_N - 1)
                            frame = i;
                    touch_frame(frame, FRM_N);
                end
                if (!found)
                    frm_tag[frame] = page;

                // TLB fill or LRU eviction
                if (tlb_used < TLB_N)
                begin
                    e = tlb_used;
                    for (i = 0; i < e; i++)
                        tlb_rank[i]++;
                    tlb_rank[e] = 0;
                    tlb_vld[e]  = 1'b1;
                    tlb_used++;
                end
                else
                begin
                    e = 0;
                    for (i = 0; i < TLB_N; i++)
                        if (tlb_rank[i] == TLB_N - 1)
                            e = i;
                    touch_tlb(e, TLB_N);
                end
                tlb_tag[e] = page;
                tlb_frm[e] = frame[6:0];
            end

            // Saturating totals
            if (hit && hits != '1)
                hits++;
            if (!hit && !found && faults != '1)
                faults++;

            res.pa          = PA_W'((frame << OFS_W) | va[OFS_W-1:0]);
            res.hit         = hit;
            res.fault       = !hit && !found;
            res.hit_total   = hits;
            res.fault_total = faults;
            return res;
        endfunction

        function void note_address(logic [15:0] va);
            pending_xlat.push_back(translate(va));
        endfunction

        function int outstanding();
            return pending_xlat.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest pending translation
        task check_result(logic [79:0] data, logic [1:0] user);
            xlat_t want;
            if (pending_xlat.size() == 0)
            begin
                report($sformatf("unexpected result, tdata %h tuser %b", data, user));
                return;
            end
            want = pending_xlat.pop_front();
            if (data[14:0] !== want.pa)
                report($sformatf("physical_address %h, want %h", data[14:0], want.pa));
            if (user[0] !== want.hit)
                report($sformatf("tlb_hit %b, want %b (pa %h)", user[0], want.hit, want.pa));
            if (user[1] !== want.fault)
                report($sformatf("page_fault %b, want %b (pa %h)", user[1], want.fault, want.pa));
            if (data[46:15] !== want.hit_total)
                report($sformatf("tlb_hit_total %0d, want %0d", data[46:15], want.hit_total));
            if (data[78:47] !== want.fault_total)
                report($sformatf("fault_total %0d, want %0d", data[78:47], want.fault_total));
            if (data[79] !== 1'b0)
                report("tdata pad bit not zero");
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // virtual_address
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // physical_address, tlb_hit_total, fault_total, pad
    logic [1:0]  m_axis_tuser;          // tlb_hit, page_fault

    bit          no_idle = 1'b0;
    xlat_tracker board;

    tlb_lru_page_translate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Present one request; tvalid only drops when a gap is taken
    task automatic send_address(input logic [15:0] va, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= va;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_address(va);
    endtask

    // Result side: random stalls, check on every accepted result
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Stimulus and end of test
    initial
    begin
        logic [7:0] hot_pages  [HOT_N];
        logic [7:0] warm_pages [WARM_N];
        logic [7:0] page;
        int         n;
        int         pick;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_VA[k])
            send_address(CORNER_VA[k], draw_wait());

        // Locality mix: hot pages hit the TLB, warm pages hit the page table,
        // wide random pages fault and force frame reclaim (stale TLB hits follow)
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                foreach (hot_pages[k])
                    hot_pages[k] = 8'($urandom_range(0, 255));
                foreach (warm_pages[k])
                    warm_pages[k] = 8'($urandom_range(0, 255));
            end
            no_idle = ((n / 100) % 4 == 3);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                page = hot_pages[$urandom_range(0, HOT_N - 1)];
            else if (pick < 75)
                page = warm_pages[$urandom_range(0, WARM_N - 1)];
            else
                page = 8'($urandom_range(0, 255));
            send_address({page, 8'($urandom_range(0, 255))}, draw_wait());
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (board.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
